>>> hw/rtl/first_fit_block_allocator_core_macros.svh
// Assertion helpers for the allocator core.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define FBAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check an implication that must hold in the cycle after its trigger.
`define FBAL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fbal_pkg.sv
`timescale 1ns / 1ps
package fbal_pkg;

  localparam int unsigned OFF_W = 16;
  localparam int unsigned ALU_W = 18;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] size;
    logic             free;
  } entry_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_op_t;

endpackage

>>> hw/rtl/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// Allocate walks the block table for the first free block that fits, shifting the entries
// above it up by one on a split; free finds the block, merges free neighbors and shifts down.
// One request at a time; the single read port of the block table and
// the shared adder set the pace.
// Reset: asynchronous, active low; the table holds one free block covering the arena.
module first_fit_block_allocator_core
  import fbal_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_ENTRIES  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_size[15:0], address[31:16]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // payload_offset[15:0], status[17:16], zero fill
);

  `include "first_fit_block_allocator_core_macros.svh"

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [OFF_W-1:0] RST_SIZE = OFF_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [ALU_W-1:0] HDR      = ALU_W'(HEADER_BYTES);
  localparam logic [ALU_W-1:0] HDR8     = ALU_W'(HEADER_BYTES + 8);
  localparam logic [CW-1:0]    MAXC     = CW'(MAX_ENTRIES);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_ASCAN = 18'h00002,
    S_AS1   = 18'h00004,
    S_AS2   = 18'h00008,
    S_ASH   = 18'h00010,
    S_AN1   = 18'h00020,
    S_AN2   = 18'h00040,
    S_AN3   = 18'h00080,
    S_AN4   = 18'h00100,
    S_AWI   = 18'h00200,
    S_AP    = 18'h00400,
    S_FSCAN = 18'h00800,
    S_FNX   = 18'h01000,
    S_FM1   = 18'h02000,
    S_FM2   = 18'h04000,
    S_FM3   = 18'h08000,
    S_FWR   = 18'h10000,
    S_FSH   = 18'h20000
  } state_e;

  // Results need no state of their own: a finished result waits in res_* until
  // the output register is free.
  state_e           state_q, state_d;
  logic             pend_q, pend_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    k_q, k_d;
  logic [IW-1:0]    scan_q, scan_d;
  logic [IW-1:0]    hit_q, hit_d;
  logic [1:0]       rm_q, rm_d;
  logic             split_q, split_d;
  logic             nfree_q, nfree_d;
  logic             m_valid_q, m_valid_d;

  logic [OFF_W-1:0] addr_q, addr_d;
  logic [16:0]      need_q, need_d;
  entry_t           h_q, h_d;
  entry_t           p_q, p_d;
  logic [OFF_W-1:0] nsize_q, nsize_d;
  logic [ALU_W-1:0] t_q, t_d;
  logic [ALU_W-1:0] u_q, u_d;
  logic [OFF_W-1:0] res_off_q, res_off_d;
  status_e          res_st_q, res_st_d;
  logic [OFF_W-1:0] m_off_q, m_off_d;
  status_e          m_st_q, m_st_d;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_res;
  logic             alu_carry;

  logic             tbl_we;
  logic [IW-1:0]    tbl_waddr, tbl_raddr;
  entry_t           tbl_wdata, tbl_rdata;

  logic             in_fire, last_entry, prev_free;
  logic [CW-1:0]    base;

  fbal_alu u_alu (
    .op_i    (alu_op),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  fbal_table #(
    .DEPTH    (MAX_ENTRIES),
    .RST_SIZE (RST_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Accept only in idle with no unsent result pending.
  assign s_axis_tready = (state_q == S_IDLE) && !pend_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_st_q, m_off_q};

  assign last_entry = (CW'(scan_q) + CW'(1)) >= count_q;
  assign prev_free  = (hit_q != IW'(0)) && p_q.free;
  assign base       = prev_free ? (CW'(hit_q) - CW'(1)) : CW'(hit_q);

  // Route the shared adder per sequencer step.
  always_comb begin
    alu_op = '{a: '0, b: '0, sub: 1'b0};
    unique case (state_q)
      S_IDLE:  alu_op = '{a: ALU_W'(s_axis_tdata[15:0]), b: ALU_W'(7), sub: 1'b0};
      S_ASCAN: alu_op = '{a: ALU_W'(tbl_rdata.size), b: ALU_W'(need_q), sub: 1'b1};
      S_AS1:   alu_op = '{a: ALU_W'(need_q), b: HDR8, sub: 1'b0};
      S_AS2:   alu_op = '{a: ALU_W'(h_q.size), b: t_q, sub: 1'b1};
      S_AN1:   alu_op = '{a: ALU_W'(h_q.off), b: ALU_W'(need_q), sub: 1'b0};
      S_AN2:   alu_op = '{a: t_q, b: HDR, sub: 1'b0};
      S_AN3:   alu_op = '{a: ALU_W'(h_q.size), b: ALU_W'(need_q), sub: 1'b1};
      S_AN4:   alu_op = '{a: u_q, b: HDR, sub: 1'b1};
      S_AP:    alu_op = '{a: ALU_W'(h_q.off), b: HDR, sub: 1'b0};
      S_FSCAN: alu_op = '{a: ALU_W'(tbl_rdata.off), b: HDR, sub: 1'b0};
      S_FM1:   alu_op = '{a: t_q, b: HDR, sub: 1'b0};
      S_FM2:   alu_op = '{a: t_q, b: ALU_W'(nsize_q), sub: 1'b0};
      S_FM3:   alu_op = '{a: t_q, b: HDR, sub: 1'b0};
      default: alu_op = '{a: t_q, b: ALU_W'(p_q.size), sub: 1'b0};
    endcase
  end

  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    count_d   = count_q;
    k_d       = k_q;
    scan_d    = scan_q;
    hit_d     = hit_q;
    rm_d      = rm_q;
    split_d   = split_q;
    nfree_d   = nfree_q;
    m_valid_d = m_valid_q;
    addr_d    = addr_q;
    need_d    = need_q;
    h_d       = h_q;
    p_d       = p_q;
    nsize_d   = nsize_q;
    t_d       = t_q;
    u_d       = u_q;
    res_off_d = res_off_q;
    res_st_d  = res_st_q;
    m_off_d   = m_off_q;
    m_st_d    = m_st_q;
    tbl_we    = 1'b0;
    tbl_waddr = hit_q;
    tbl_wdata = h_q;
    tbl_raddr = IW'(scan_q + IW'(1));

    // Drain the output register, then load a pending result.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (pend_q && (!m_valid_q || m_axis_tready)) begin
      m_valid_d = 1'b1;
      m_off_d   = res_off_q;
      m_st_d    = res_st_q;
      pend_d    = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        tbl_raddr = IW'(0);
        scan_d    = IW'(0);
        if (in_fire) begin
          addr_d = s_axis_tdata[31:16];
          need_d = alu_res[16:0] & ~17'd7;
          if (op_e'(s_axis_tuser) == OP_FREE) begin
            state_d = S_FSCAN;
          end else if (s_axis_tdata[15:0] == '0) begin
            res_off_d = '0;
            res_st_d  = ST_NOFIT;
            pend_d    = 1'b1;
          end else begin
            state_d = S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        if (tbl_rdata.free && alu_carry) begin
          hit_d   = scan_q;
          h_d     = tbl_rdata;
          state_d = S_AS1;
        end else if (last_entry) begin
          res_off_d = '0;
          res_st_d  = ST_NOFIT;
          pend_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          scan_d = scan_q + IW'(1);
        end
      end
      S_AS1: begin
        t_d     = alu_res;
        state_d = S_AS2;
      end
      S_AS2: begin
        split_d   = alu_carry && (count_q < MAXC);
        k_d       = count_q;
        tbl_raddr = IW'(count_q - CW'(1));
        state_d   = (alu_carry && (count_q < MAXC)) ? S_ASH : S_AWI;
      end
      S_ASH: begin
        // Move entries up by one, reading two below the write slot.
        if (k_q > (CW'(hit_q) + CW'(1))) begin
          tbl_we    = 1'b1;
          tbl_waddr = IW'(k_q);
          tbl_wdata = tbl_rdata;
          tbl_raddr = IW'(k_q - CW'(2));
          k_d       = k_q - CW'(1);
        end else begin
          state_d = S_AN1;
        end
      end
      S_AN1: begin
        t_d     = alu_res;
        state_d = S_AN2;
      end
      S_AN2: begin
        t_d     = alu_res;
        state_d = S_AN3;
      end
      S_AN3: begin
        u_d     = alu_res;
        state_d = S_AN4;
      end
      S_AN4: begin
        tbl_we    = 1'b1;
        tbl_waddr = hit_q + IW'(1);
        tbl_wdata = '{off: t_q[OFF_W-1:0], size: alu_res[OFF_W-1:0], free: 1'b1};
        count_d   = count_q + CW'(1);
        state_d   = S_AWI;
      end
      S_AWI: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{off: h_q.off, size: split_q ? need_q[OFF_W-1:0] : h_q.size,
                      free: 1'b0};
        state_d   = S_AP;
      end
      S_AP: begin
        res_off_d = alu_res[OFF_W-1:0];
        res_st_d  = ST_OK;
        pend_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_FSCAN: begin
        if (alu_res[OFF_W-1:0] == addr_q) begin
          hit_d = scan_q;
          h_d   = tbl_rdata;
          if (tbl_rdata.free) begin
            res_off_d = '0;
            res_st_d  = ST_DOUBLE;
            pend_d    = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d = S_FNX;
          end
        end else if (last_entry) begin
          res_off_d = '0;
          res_st_d  = ST_UNKNOWN;
          pend_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          p_d    = tbl_rdata;
          scan_d = scan_q + IW'(1);
        end
      end
      S_FNX: begin
        // The entry above the hit arrives from the read issued during the scan.
        nfree_d = ((CW'(hit_q) + CW'(1)) < count_q) && tbl_rdata.free;
        nsize_d = tbl_rdata.size;
        t_d     = ALU_W'(h_q.size);
        state_d = S_FM1;
      end
      S_FM1: begin
        if (nfree_q) begin
          t_d     = alu_res;
          state_d = S_FM2;
        end else begin
          state_d = S_FM3;
        end
      end
      S_FM2: begin
        t_d     = alu_res;
        state_d = S_FM3;
      end
      S_FM3: begin
        if (prev_free) begin
          t_d     = alu_res;
          state_d = S_FWR;
          split_d = 1'b1;
        end else begin
          state_d = S_FWR;
          split_d = 1'b0;
        end
      end
      S_FWR: begin
        // Fold in the lower neighbor first, then write the merged block.
        if (split_q) begin
          t_d     = alu_res;
          split_d = 1'b0;
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = IW'(base);
          tbl_wdata = '{off: prev_free ? p_q.off : h_q.off, size: t_q[OFF_W-1:0],
                        free: 1'b1};
          rm_d      = {1'b0, nfree_q} + {1'b0, prev_free};
          k_d       = base + CW'(1);
          tbl_raddr = IW'(base + CW'(1) + CW'({1'b0, nfree_q}) + CW'({1'b0, prev_free}));
          state_d   = S_FSH;
        end
      end
      S_FSH: begin
        if (({1'b0, k_q} + (CW + 1)'(rm_q)) < {1'b0, count_q}) begin
          tbl_we    = 1'b1;
          tbl_waddr = IW'(k_q);
          tbl_wdata = tbl_rdata;
          tbl_raddr = IW'(k_q + CW'(1) + CW'(rm_q));
          k_d       = k_q + CW'(1);
        end else begin
          count_d   = count_q - CW'(rm_q);
          res_off_d = '0;
          res_st_d  = ST_OK;
          pend_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      count_q   <= CW'(1);
      k_q       <= '0;
      scan_q    <= '0;
      hit_q     <= '0;
      rm_q      <= '0;
      split_q   <= 1'b0;
      nfree_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      count_q   <= count_d;
      k_q       <= k_d;
      scan_q    <= scan_d;
      hit_q     <= hit_d;
      rm_q      <= rm_d;
      split_q   <= split_d;
      nfree_q   <= nfree_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    need_q    <= need_d;
    h_q       <= h_d;
    p_q       <= p_d;
    nsize_q   <= nsize_d;
    t_q       <= t_d;
    u_q       <= u_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
    m_off_q   <= m_off_d;
    m_st_q    <= m_st_d;
  end

  `FBAL_ASSERT(a_count_range, (count_q != '0) && (count_q <= MAXC), "block count out of range")
  `FBAL_ASSERT_NEXT(a_one_at_a_time, in_fire, !s_axis_tready, "accepted while busy")
  `FBAL_ASSERT(a_err_zero_off, (m_valid_q && (m_st_q != ST_OK)) |-> (m_off_q == '0), "error with offset")
  `FBAL_ASSERT_NEXT(a_alloc_zero, in_fire && !s_axis_tuser && (s_axis_tdata[15:0] == '0),
                    pend_q && (res_st_q == ST_NOFIT) || (m_valid_q && (m_st_q == ST_NOFIT)),
                    "zero size not refused")

endmodule

>>> hw/rtl/fbal_alu.sv
`timescale 1ns / 1ps
module fbal_alu
  import fbal_pkg::*;
(
  input  alu_op_t          op_i,
  output logic [ALU_W-1:0] res_o,
  output logic             carry_o
);

  logic [ALU_W:0] sum;

  // Subtract as a plus inverted b plus one; carry out means a >= b.
  assign sum     = {1'b0, op_i.a} + {1'b0, (op_i.sub ? ~op_i.b : op_i.b)}
                 + {{ALU_W{1'b0}}, op_i.sub};
  assign res_o   = sum[ALU_W-1:0];
  assign carry_o = sum[ALU_W];

endmodule

>>> hw/rtl/fbal_table.sv
`timescale 1ns / 1ps
module fbal_table
  import fbal_pkg::*;
#(
  parameter int unsigned     DEPTH    = 256,
  parameter logic [OFF_W-1:0] RST_SIZE = 16'hFFF0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  localparam int unsigned IW = $clog2(DEPTH);

  entry_t mem [DEPTH];
  entry_t mem_rd_q;
  logic   e0_written_q;
  logic   rd_rst_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    mem_rd_q <= mem[raddr_i];
  end

  // Entry zero reads as the initial arena block until first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_written_q <= 1'b0;
      rd_rst_q     <= 1'b0;
    end else begin
      if (we_i && (waddr_i == IW'(0))) begin
        e0_written_q <= 1'b1;
      end
      rd_rst_q <= (raddr_i == IW'(0)) && !e0_written_q;
    end
  end

  assign rdata_o = rd_rst_q ? entry_t'{off: '0, size: RST_SIZE, free: 1'b1} : mem_rd_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import fbal_pkg::*;

  localparam int unsigned ARENA  = 65536;
  localparam int unsigned HDR    = 16;
  localparam int unsigned NSLOTS = 256;

  typedef struct {
    logic [15:0] off;
    status_e     st;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  first_fit_block_allocator_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow block table.
  int unsigned blk_off [NSLOTS];
  int unsigned blk_size[NSLOTS];
  bit          blk_free[NSLOTS];
  int unsigned blk_count;

  grant_t      grants_due[$];
  logic [15:0] live_addr[$];
  logic [15:0] dead_addr[$];
  int          errors = 0;
  bit          calm = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic grant_t table_alloc(input int unsigned req);
    grant_t g;
    int unsigned need;
    g.off = '0;
    g.st  = ST_NOFIT;
    if (req == 0) return g;
    need = (req + 7) & ~32'd7;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= need) begin
        if (blk_size[i] >= need + HDR + 8 && blk_count < NSLOTS) begin
          for (int unsigned k = blk_count; k > i + 1; k--) begin
            blk_off[k]  = blk_off[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
          end
          blk_off[i+1]  = blk_off[i] + HDR + need;
          blk_size[i+1] = blk_size[i] - need - HDR;
          blk_free[i+1] = 1'b1;
          blk_size[i]   = need;
          blk_count++;
        end
        blk_free[i] = 1'b0;
        g.off = 16'(blk_off[i] + HDR);
        g.st  = ST_OK;
        return g;
      end
    end
    return g;
  endfunction

  function automatic grant_t table_release(input logic [15:0] addr);
    grant_t g;
    int unsigned hit;
    int unsigned i;
    g.off = '0;
    hit = NSLOTS;
    for (i = 0; i < blk_count; i++)
      if (16'(blk_off[i] + HDR) == addr) begin
        hit = i;
        break;
      end
    if (hit >= NSLOTS) begin
      g.st = ST_UNKNOWN;
      return g;
    end
    if (blk_free[hit]) begin
      g.st = ST_DOUBLE;
      return g;
    end
    blk_free[hit] = 1'b1;
    i = 0;
    // Merge touching free neighbors, rescanning from the same slot.
    while (i + 1 < blk_count) begin
      if (blk_free[i] && blk_free[i+1] && blk_off[i] + HDR + blk_size[i] == blk_off[i+1]) begin
        blk_size[i] += HDR + blk_size[i+1];
        for (int unsigned k = i + 1; k + 1 < blk_count; k++) begin
          blk_off[k]  = blk_off[k+1];
          blk_size[k] = blk_size[k+1];
          blk_free[k] = blk_free[k+1];
        end
        blk_count--;
      end else begin
        i++;
      end
    end
    g.st = ST_OK;
    return g;
  endfunction

  // Send one request; predict its grant on acceptance.
  task automatic send_req(input op_e op, input logic [15:0] size, input logic [15:0] addr);
    int gap;
    grant_t g;
    gap = calm ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {addr, size};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    g = (op == OP_ALLOC) ? table_alloc(size) : table_release(addr);
    grants_due.push_back(g);
    if (op == OP_ALLOC && g.st == ST_OK) live_addr.push_back(g.off);
  endtask

  task automatic free_live(input int idx);
    logic [15:0] a;
    a = live_addr[idx];
    live_addr.delete(idx);
    dead_addr.push_back(a);
    send_req(OP_FREE, 16'($urandom), a);
  endtask

  task automatic free_all();
    while (live_addr.size() > 0) free_live(0);
  endtask

  // Receiver stalls.
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 8);
      @(negedge clk_i);
      if (n > 0) begin
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grants_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        g = grants_due.pop_front();
        if (m_axis_tdata[15:0] !== g.off)
          report_mismatch($sformatf("offset %h, want %h", m_axis_tdata[15:0], g.off));
        if (m_axis_tdata[17:16] !== g.st)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tdata[17:16], g.st));
        if (m_axis_tdata[23:18] !== 6'd0)
          report_mismatch($sformatf("fill bits %h", m_axis_tdata[23:18]));
      end
    end
  end

  task automatic test_corners();
    send_req(OP_ALLOC, 16'd0, 16'hFFFF);       // zero size
    send_req(OP_ALLOC, 16'hFFFF, 16'h0000);    // larger than arena
    send_req(OP_FREE, 16'h0000, 16'h0000);     // address zero unknown
    send_req(OP_ALLOC, 16'(ARENA - HDR), 16'h1234); // whole arena
    send_req(OP_ALLOC, 16'd1, 16'd0);          // nothing left
    send_req(OP_FREE, 16'hFFFF, 16'd16);
    send_req(OP_FREE, 16'h0, 16'd16);          // double free
    send_req(OP_ALLOC, 16'(ARENA - HDR - 24), 16'h0); // split just fits
    send_req(OP_ALLOC, 16'(ARENA - HDR - 23), 16'h0); // no fit, only the small remainder is free
    free_all();
    send_req(OP_ALLOC, 16'd1, 16'h0);
    send_req(OP_ALLOC, 16'd7, 16'h0);
    send_req(OP_ALLOC, 16'd9, 16'h0);
    send_req(OP_FREE, 16'h0, 16'd17);          // unknown, mid block
    send_req(OP_FREE, 16'h0, 16'hFFFF);
    free_live(1);
    free_live(0);
    free_all();
  endtask

  // Fill the table so splits stop and whole blocks are granted.
  task automatic test_full_table();
    calm = 1'b1;
    repeat (NSLOTS + 2) send_req(OP_ALLOC, 16'd8, 16'($urandom));
    calm = 1'b0;
    send_req(OP_ALLOC, 16'd8, 16'h0);
    repeat (40) begin
      if (live_addr.size() > 0) free_live($urandom_range(0, live_addr.size() - 1));
    end
  endtask

  task automatic test_random(input int count);
    int r;
    logic [15:0] sz;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 50 || live_addr.size() == 0) begin
        sz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
        send_req(OP_ALLOC, sz, 16'($urandom));
      end else if (r < 85) begin
        free_live($urandom_range(0, live_addr.size() - 1));
      end else if (r < 92 && dead_addr.size() > 0) begin
        send_req(OP_FREE, 16'($urandom), dead_addr[$urandom_range(0, dead_addr.size() - 1)]);
      end else begin
        send_req(OP_FREE, 16'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 63) == 0) calm = ~calm;
    end
    calm = 1'b0;
  endtask

  initial begin
    blk_off[0] = 0;
    blk_size[0] = ARENA - HDR;
    blk_free[0] = 1'b1;
    blk_count = 1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_corners();
    test_full_table();
    test_random(80);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (grants_due.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/fbal_pkg.sv
hw/rtl/fbal_alu.sv
hw/rtl/fbal_table.sv
hw/rtl/first_fit_block_allocator_core.sv
tb/tb.sv
